// File: sv/frame_warp_linear_interp_unit_macros.svh
// -----------------------------------------------------------------------------
// Frame warp interpolation unit assertion macros
// Shared property forms used by the port-level checker.
// -----------------------------------------------------------------------------
`ifndef FRAME_WARP_LINEAR_INTERP_UNIT_MACROS_SVH
`define FRAME_WARP_LINEAR_INTERP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FWLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fwli same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FWLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fwli next-cycle check failed");

`endif

// File: sv/fwli_pkg.sv
// -----------------------------------------------------------------------------
// Frame warp interpolation package
// Widths, codes and types shared by the frame warp interpolation unit.
// -----------------------------------------------------------------------------
package fwli_pkg;

	localparam int FRAME_MAX   = 1024;
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;

	localparam int ADDR_W  = $clog2(FRAME_MAX);
	localparam int POS_W   = 10;
	localparam int LEN_W   = 11;
	localparam int SCALE_W = 24;
	localparam int P1_W    = POS_W + SCALE_W;
	localparam int HALF_W  = (P1_W + 1) / 2;
	localparam int LO_W    = HALF_W + SCALE_W;
	localparam int PROD_W  = P1_W + SCALE_W;
	localparam int BASE_W  = PROD_W - 2 * FRAC_BITS;
	localparam int DIFF_W  = SAMPLE_BITS + 1;
	localparam int MUL_W   = DIFF_W + FRAC_BITS + 1;
	localparam int Q_W     = MUL_W - FRAC_BITS;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
	localparam logic [1:0] REG_STRETCH      = 2'd1;
	localparam logic [1:0] REG_ENABLE       = 2'd2;

	localparam logic [LEN_W-1:0]   FRAME_LENGTH_RST = LEN_W'(64);
	localparam logic [SCALE_W-1:0] STRETCH_RST      = SCALE_W'(65536);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INDEX,
		ST_READ,
		ST_INTERP
	} fsm_t;

	typedef struct packed {
		logic                 done;
		logic [BASE_W-1:0]    base;
		logic [FRAC_BITS-1:0] frac;
	} idx_res_t;

endpackage

// File: sv/fwli_ram.sv
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// -----------------------------------------------------------------------------
module fwli_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: sv/fwli_index.sv
// -----------------------------------------------------------------------------
// Fractional index unit
// Forms position * stretch * warp in four registered multiply and add steps.
// -----------------------------------------------------------------------------
module fwli_index
	import fwli_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [POS_W-1:0]   position,
	input  logic [SCALE_W-1:0] stretch,
	input  logic [SCALE_W-1:0] warp,
	output idx_res_t           res
);

	logic                       v_s1, v_s2, v_s3, v_s4;
	logic [P1_W-1:0]            p1_s1;
	logic [SCALE_W-1:0]         warp_s1, warp_s2;
	logic [LO_W-1:0]            lo_s2, lo_s3, hi_s3;
	logic [P1_W-HALF_W-1:0]     p1hi_s2;
	logic [BASE_W-1:0]          base_s4;
	logic [FRAC_BITS-1:0]       frac_s4;
	logic [PROD_W-1:0]          sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign sum = (PROD_W'(hi_s3) << HALF_W) + PROD_W'(lo_s3);

	always_ff @(posedge clk) begin
		p1_s1   <= P1_W'(position) * P1_W'(stretch);
		warp_s1 <= warp;
		lo_s2   <= LO_W'(p1_s1[HALF_W-1:0]) * LO_W'(warp_s1);
		p1hi_s2 <= p1_s1[P1_W-1:HALF_W];
		warp_s2 <= warp_s1;
		hi_s3   <= LO_W'(p1hi_s2) * LO_W'(warp_s2);
		lo_s3   <= lo_s2;
		base_s4 <= sum[PROD_W-1:2*FRAC_BITS];
		frac_s4 <= sum[2*FRAC_BITS-1:FRAC_BITS];
	end

	assign res.done = v_s4;
	assign res.base = base_s4;
	assign res.frac = frac_s4;

endmodule

// File: sv/fwli_interp.sv
// -----------------------------------------------------------------------------
// Linear interpolator
// Blends two stored samples by a fraction, truncating toward zero.
// -----------------------------------------------------------------------------
module fwli_interp
	import fwli_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [SAMPLE_BITS-1:0] a_raw,
	input  logic signed [SAMPLE_BITS-1:0] b_raw,
	input  logic                          a_ok,
	input  logic                          b_ok,
	input  logic [FRAC_BITS-1:0]          frac,
	input  logic                          enable,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] value
);

	logic signed [SAMPLE_BITS-1:0] a_v, b_v, a_s1, value_s2;
	logic signed [DIFF_W-1:0]      diff;
	logic signed [MUL_W-1:0]       prod_s1, biased;
	logic signed [Q_W-1:0]         quot;
	logic signed [Q_W-1:0]         total;
	logic                          v_s1, v_s2;

	assign a_v  = a_ok ? a_raw : '0;
	assign b_v  = b_ok ? b_raw : '0;
	assign diff = DIFF_W'(b_v) - DIFF_W'(a_v);

	// Rounding toward zero: bias negative products before the arithmetic shift.
	assign biased = prod_s1[MUL_W-1] ? (prod_s1 + MUL_W'((1 << FRAC_BITS) - 1)) : prod_s1;
	assign quot   = Q_W'(biased >>> FRAC_BITS);
	assign total  = Q_W'(a_s1) + quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= MUL_W'(diff) * $signed(MUL_W'({1'b0, frac}));
		a_s1     <= a_v;
		value_s2 <= enable ? total[SAMPLE_BITS-1:0] : '0;
	end

	assign out_valid = v_s2;
	assign value     = value_s2;

endmodule

// File: sv/frame_warp_linear_interp_unit.sv
// -----------------------------------------------------------------------------
// Frame warp linear interpolation unit
// A load beat writes the frame store in its accept cycle; busy stays low.
// An emit beat passes the four-step index multiply, the store read and the
// two-step interpolation; busy is high while it is in flight and low when done
// shows its result, so a new emit is taken only once the last one is through.
// Reset clears control state and sets the registers; the store is not cleared.
// -----------------------------------------------------------------------------
module frame_warp_linear_interp_unit
	import fwli_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [POS_W-1:0]              position,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [SCALE_W-1:0]            warp,
	output logic                          done,
	output logic [POS_W-1:0]              out_position,
	output logic signed [SAMPLE_BITS-1:0] value,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_W-1:0]            paddr,
	input  logic [PDATA_W-1:0]            pwdata,
	output logic [PDATA_W-1:0]            prdata,
	output logic                          pready
);

	fsm_t                 state_q, state_nxt;
	logic [LEN_W-1:0]     frame_length_q, len_eff;
	logic [SCALE_W-1:0]   stretch_q;
	logic                 enable_q;
	logic [POS_W-1:0]     pos_q;
	logic                 a_ok_q, b_ok_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic                 accept, idx_start, load_we, interp_go, cfg_we;
	idx_res_t             idx_res;
	logic [ADDR_W-1:0]    addr_a, addr_b;
	logic [SAMPLE_BITS-1:0] rdata_a, rdata_b;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;
	assign accept = start & ~busy;
	assign load_we = accept & (opcode == OP_LOAD) & ({1'b0, position} < LEN_W'(FRAME_MAX));
	assign len_eff = (frame_length_q > LEN_W'(FRAME_MAX)) ? LEN_W'(FRAME_MAX) : frame_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= FRAME_LENGTH_RST;
			stretch_q      <= STRETCH_RST;
			enable_q       <= 1'b1;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_FRAME_LENGTH: frame_length_q <= pwdata[LEN_W-1:0];
				REG_STRETCH:      stretch_q      <= pwdata[SCALE_W-1:0];
				REG_ENABLE:       enable_q       <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FRAME_LENGTH: prdata = PDATA_W'(frame_length_q);
			REG_STRETCH:      prdata = PDATA_W'(stretch_q);
			REG_ENABLE:       prdata = PDATA_W'(enable_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		busy      = 1'b1;
		idx_start = 1'b0;
		interp_go = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && (opcode == OP_EMIT)) begin
					idx_start = 1'b1;
					state_nxt = ST_INDEX;
				end
			end
			ST_INDEX: begin
				if (idx_res.done) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				interp_go = 1'b1;
				state_nxt = ST_INTERP;
			end
			ST_INTERP: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (idx_start) begin
			pos_q <= position;
		end
		if (idx_res.done) begin
			a_ok_q <= idx_res.base < BASE_W'(len_eff);
			b_ok_q <= ((BASE_W + 1)'(idx_res.base) + (BASE_W + 1)'(1)) < (BASE_W + 1)'(len_eff);
			frac_q <= idx_res.frac;
		end
	end

	assign addr_a = idx_res.base[ADDR_W-1:0];
	assign addr_b = idx_res.base[ADDR_W-1:0] + ADDR_W'(1);

	fwli_index u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (idx_start),
		.position (position),
		.stretch  (stretch_q),
		.warp     (warp),
		.res      (idx_res)
	);

	fwli_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (FRAME_MAX)
	) u_store (
		.clk     (clk),
		.we      (load_we),
		.waddr   (position[ADDR_W-1:0]),
		.wdata   (sample),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	fwli_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (interp_go),
		.a_raw     (rdata_a),
		.b_raw     (rdata_b),
		.a_ok      (a_ok_q),
		.b_ok      (b_ok_q),
		.frac      (frac_q),
		.enable    (enable_q),
		.out_valid (done),
		.value     (value)
	);

	assign out_position = pos_q;

endmodule

// File: sv/fwli_checker.sv
// -----------------------------------------------------------------------------
// Frame warp interpolation port checker
// Watches the command and result ports of the unit over time.
// -----------------------------------------------------------------------------
`include "frame_warp_linear_interp_unit_macros.svh"

module fwli_checker
	import fwli_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic done
);

	logic emit_beat, load_beat;

	assign emit_beat = start && !busy && (opcode == OP_EMIT);
	assign load_beat = start && !busy && (opcode == OP_LOAD);

	`FWLI_ASSERT_NXT(a_emit_busy, clk, arst_n, emit_beat, busy)
	`FWLI_ASSERT_NXT(a_load_free, clk, arst_n, load_beat, !busy)
	`FWLI_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`FWLI_ASSERT_IMP(a_done_cause, clk, arst_n, done, $past(emit_beat, 7))

endmodule

bind frame_warp_linear_interp_unit fwli_checker u_fwli_checker (.*);
